FILE: rtl/core/afrl_pkg.sv
package afrl_pkg;

    localparam int AFRL_FLOWS = 16;

    localparam int FLOW_W  = 4;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int CNT_W   = 4;
    localparam int STAT_W  = 10;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_REQUEST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESPONSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CRAWL    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DLY_CAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT = 2'd2;

    localparam logic [DELAY_W-1:0] DLY_CAP_RST   = 16'd15360;
    localparam logic [DELAY_W-1:0] BASE_MIN_RST  = 16'd256;
    localparam logic [CNT_W-1:0]   ERR_LIMIT_RST = 4'd3;
    localparam logic [DELAY_W-1:0] DELAY_RST     = 16'd256;
    localparam logic [STAT_W-1:0]  ERROR_STATUS  = 10'd400;
    localparam logic [CNT_W-1:0]   CNT_MAX       = 4'd15;
    localparam logic [DELAY_W-1:0] WAIT_SAT      = 16'hFFFF;

    // reciprocal of five for 16 bit operands, shift of 18
    localparam logic [33:0] RECIP5 = 34'd52429;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FLOW_W-1:0]  flow;
        logic [TIME_W-1:0]  now;
        logic [DELAY_W-1:0] resp_time;
        logic [STAT_W-1:0]  resp_status;
        logic [DELAY_W-1:0] crawl_delay;
    } t_in_item;

    typedef struct packed {
        logic [DELAY_W-1:0] wait_time;
        logic [DELAY_W-1:0] delay_now;
        logic [FLOW_W-1:0]  flow_out;
    } t_out_item;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] floor_dly;
        logic [CNT_W-1:0]   err_cnt;
        logic [TIME_W-1:0]  release_time;
    } t_tab_entry;

    typedef struct packed {
        logic [DELAY_W-1:0] dly_cap;
        logic [DELAY_W-1:0] base_floor;
        logic [CNT_W-1:0]   error_limit;
    } t_cfg;

endpackage

FILE: rtl/core/afrl_table.sv
module afrl_table import afrl_pkg::*; #(
    parameter int DEPTH = AFRL_FLOWS,
    parameter int IW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_idx,
    input  logic          i_we,
    input  t_tab_entry    i_wr_entry,
    output t_tab_entry    o_rd_entry
);

    t_tab_entry r_tab [DEPTH];

    // read and write share the address of the item in the compute stage
    assign o_rd_entry = r_tab[i_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_tab[i].delay        <= DELAY_RST;
                r_tab[i].floor_dly    <= DELAY_RST;
                r_tab[i].err_cnt      <= '0;
                r_tab[i].release_time <= '0;
            end
        end else if (i_we) begin
            r_tab[i_idx] <= i_wr_entry;
        end
    end

endmodule

FILE: rtl/core/afrl_update.sv
module afrl_update import afrl_pkg::*; (
    input  t_in_item   i_item,
    input  t_tab_entry i_entry,
    input  t_cfg       i_cfg,
    output t_tab_entry o_entry,
    output t_out_item  o_result
);

    logic [DELAY_W-1:0] delay;
    logic [TIME_W-1:0]  rel;
    logic [TIME_W:0]    diff;
    logic [TIME_W-1:0]  ahead;
    logic [TIME_W:0]    ahead_sum;
    logic [TIME_W-1:0]  rel_plus;
    logic [DELAY_W-1:0] wait_q;
    logic [TIME_W-1:0]  rel_n;
    logic [CNT_W-1:0]   cnt_inc;
    logic [DELAY_W:0]   dbl;
    logic [DELAY_W+1:0] tri3;
    logic [DELAY_W:0]   half3;
    logic [DELAY_W:0]   rt2;
    logic [33:0]        prod;
    logic [DELAY_W-1:0] q5;
    logic [DELAY_W-1:0] r5_full;
    logic [2:0]         r5;
    logic [DELAY_W-1:0] four_fifth;
    logic [DELAY_W-1:0] mn;

    assign delay = i_entry.delay;
    assign rel   = i_entry.release_time;

    // request timing
    assign diff      = {1'b0, i_item.now} - {1'b0, rel};
    assign ahead     = rel - i_item.now;
    assign ahead_sum = {1'b0, ahead} + {17'b0, delay};
    assign rel_plus  = rel + {16'b0, delay};

    always_comb begin
        if (!diff[TIME_W]) begin
            if (diff[TIME_W-1:0] < {16'b0, delay}) begin
                wait_q = delay - diff[DELAY_W-1:0];
                rel_n  = rel_plus;
            end else begin
                wait_q = '0;
                rel_n  = i_item.now;
            end
        end else begin
            wait_q = (ahead_sum[TIME_W:DELAY_W] != '0) ? WAIT_SAT : ahead_sum[DELAY_W-1:0];
            rel_n  = rel_plus;
        end
    end

    // delay adaption terms
    assign cnt_inc = (i_entry.err_cnt < CNT_MAX) ? i_entry.err_cnt + 4'd1 : CNT_MAX;
    assign dbl     = {delay, 1'b0};
    assign tri3    = {1'b0, delay, 1'b0} + {2'b0, delay};
    assign half3   = tri3[DELAY_W+1:1];
    assign rt2     = {i_item.resp_time, 1'b0};

    // floor(4d/5) = 4*(d/5) + floor(4*(d%5)/5)
    assign prod       = {18'b0, delay} * RECIP5;
    assign q5         = prod[33:18];
    assign r5_full    = delay - ({q5[DELAY_W-3:0], 2'b00} + q5);
    assign r5         = r5_full[2:0];
    assign four_fifth = {q5[DELAY_W-3:0], 2'b00}
                      + ((r5 == 3'd0) ? 16'd0 : {13'b0, r5 - 3'd1});

    assign mn = (i_item.crawl_delay > i_cfg.base_floor) ? i_item.crawl_delay
                                                        : i_cfg.base_floor;

    always_comb begin
        o_entry = i_entry;
        o_result.wait_time = '0;
        case (i_item.cmd)
            CMD_REQUEST: begin
                o_entry.release_time = rel_n;
                o_result.wait_time   = wait_q;
            end
            CMD_RESPONSE: begin
                if (i_item.resp_status >= ERROR_STATUS) begin
                    if (cnt_inc >= i_cfg.error_limit) begin
                        o_entry.err_cnt = '0;
                        o_entry.delay   = (dbl < {1'b0, i_cfg.dly_cap}) ? dbl[DELAY_W-1:0]
                                                                        : i_cfg.dly_cap;
                    end else begin
                        o_entry.err_cnt = cnt_inc;
                    end
                end else begin
                    o_entry.err_cnt = '0;
                    if (i_item.resp_time > delay) begin
                        o_entry.delay = (half3 < {1'b0, i_cfg.dly_cap})
                                      ? half3[DELAY_W-1:0] : i_cfg.dly_cap;
                    end else if (rt2 < {1'b0, delay}) begin
                        o_entry.delay = (four_fifth > i_entry.floor_dly)
                                      ? four_fifth : i_entry.floor_dly;
                    end
                end
            end
            CMD_CRAWL: begin
                o_entry.floor_dly = mn;
                o_entry.delay     = (delay > mn) ? delay : mn;
            end
            default: begin
                // unused command leaves the entry alone
            end
        endcase
        o_result.delay_now = o_entry.delay;
        o_result.flow_out  = i_item.flow;
    end

endmodule

FILE: rtl/core/adaptive_per_flow_rate_limiter_unit.sv
// channel   dir   handshake                      payload
// in        in    i_in_valid / o_in_stall        i_in_data  (t_in_item)
// out       out   o_out_valid / i_out_stall      o_out_data (t_out_item)
// cfg       in    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// one item per cycle while the output is not stalled; an item passes the input register,
// then the result register; input and result registers frame the update
// the flow table is flip-flops, cleared by the synchronous reset
// a stalled result holds in the result register while one more item waits in
// the input register; o_in_stall rises only when both are full
// configuration writes are always taken
module adaptive_per_flow_rate_limiter_unit import afrl_pkg::*; #(
    parameter int FLOWS = AFRL_FLOWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // only sixteen flows are addressable by the flow field
    localparam int DEPTH = (FLOWS < 16) ? FLOWS : 16;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dly_cap     <= DLY_CAP_RST;
            r_cfg.base_floor  <= BASE_MIN_RST;
            r_cfg.error_limit <= ERR_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DLY_CAP:   r_cfg.dly_cap     <= i_cfg_data;
                REG_BASE_MIN:  r_cfg.base_floor  <= i_cfg_data;
                REG_ERR_LIMIT: r_cfg.error_limit <= i_cfg_data[CNT_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // input register
    logic     r_in_vld;
    t_in_item r_in;
    logic     r_out_vld;
    t_out_item r_out;
    logic     out_free;
    logic     adv;
    logic     in_xfer;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign adv        = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    // flow index reduced modulo the flow count
    logic [IW-1:0] idx;

    always_comb begin
        idx = '0;
        for (int i = 0; i < 16; i++) begin
            if (r_in.flow == FLOW_W'(i)) begin
                idx = IW'(i % FLOWS);
            end
        end
    end

    // table read, update, write back on advance
    t_tab_entry rd_entry;
    t_tab_entry wr_entry;
    t_out_item  result;

    afrl_table #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_idx      (idx),
        .i_we       (adv),
        .i_wr_entry (wr_entry),
        .o_rd_entry (rd_entry)
    );

    afrl_update u_update (
        .i_item   (r_in),
        .i_entry  (rd_entry),
        .i_cfg    (r_cfg),
        .o_entry  (wr_entry),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // checks
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled while a register is free");

    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out_valid)
        else $error("advanced item did not reach the result register");

    a_flow_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (o_out_data.flow_out == $past(r_in.flow)))
        else $error("result flow does not match the item");

endmodule

FILE: test/tb_adaptive_per_flow_rate_limiter_unit.sv
module tb_adaptive_per_flow_rate_limiter_unit;
    import afrl_pkg::*;

    // the block has no code for cmd 3, it must leave the flow untouched
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int PHASES      = 8;
    localparam int RAND_PHASE  = 6;
    localparam int PHASE_ITEMS = 192;
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 400000;

    // register settings per phase, extremes included
    localparam logic [DELAY_W-1:0] CAP_SET [PHASES] =
        '{16'd15360, 16'd65535, 16'd1, 16'd2000, 16'd40000, 16'd100, 16'd0, 16'd65535};
    localparam logic [DELAY_W-1:0] BASE_SET [PHASES] =
        '{16'd256, 16'd0, 16'd65535, 16'd100, 16'd1000, 16'd2000, 16'd0, 16'd256};
    localparam logic [CNT_W-1:0] TRIP_SET [PHASES] =
        '{4'd3, 4'd1, 4'd15, 4'd2, 4'd5, 4'd4, 4'd0, 4'd0};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the flow table and the registers
    logic [DELAY_W-1:0] flow_delay   [AFRL_FLOWS];
    logic [DELAY_W-1:0] flow_floor   [AFRL_FLOWS];
    logic [CNT_W-1:0]   flow_errs    [AFRL_FLOWS];
    logic [TIME_W-1:0]  flow_release [AFRL_FLOWS];
    logic [DELAY_W-1:0] cap_delay;
    logic [DELAY_W-1:0] floor_delay;
    logic [CNT_W-1:0]   err_trip;

    t_in_item  limiter_items [$];
    t_out_item predicted [$];
    t_out_item want;

    int  mismatches = 0;
    int  cycle_cnt = 0;
    int  tx_gap = 0;
    int  rx_wait = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;

    adaptive_per_flow_rate_limiter_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // hold time and new delay of one flow for one command, table updated in place
    function automatic t_out_item pace_flow(input t_in_item it);
        t_out_item   res;
        logic [31:0] dly;
        logic [31:0] rel;
        logic [31:0] lapse;
        logic [31:0] mn;
        logic [63:0] hold;
        logic [CNT_W-1:0] cnt;
        int unsigned f;
        f = 32'(it.flow);
        dly = 32'(flow_delay[f]);
        hold = '0;
        case (it.cmd)
            CMD_REQUEST: begin
                rel = flow_release[f];
                if (it.now >= rel) begin
                    lapse = it.now - rel;
                    if (lapse < dly) hold = 64'(dly - lapse);
                end else begin
                    hold = 64'(rel - it.now) + 64'(dly);
                end
                // release wraps at 32 bits, only the reported wait saturates
                flow_release[f] = 32'(64'(it.now) + hold);
            end
            CMD_RESPONSE: begin
                if (it.resp_status >= ERROR_STATUS) begin
                    cnt = flow_errs[f];
                    if (cnt != CNT_MAX) cnt = cnt + 4'd1;
                    // a limit of zero trips on every error
                    if (cnt >= err_trip) begin
                        dly = dly * 2;
                        if (dly > 32'(cap_delay)) dly = 32'(cap_delay);
                        cnt = '0;
                    end
                    flow_errs[f] = cnt;
                end else begin
                    flow_errs[f] = '0;
                    if (32'(it.resp_time) > dly) begin
                        dly = (dly * 3) / 2;
                        if (dly > 32'(cap_delay)) dly = 32'(cap_delay);
                    end else if (32'(it.resp_time) * 2 < dly) begin
                        dly = (dly * 4) / 5;
                        if (dly < 32'(flow_floor[f])) dly = 32'(flow_floor[f]);
                    end
                end
                flow_delay[f] = dly[DELAY_W-1:0];
            end
            CMD_CRAWL: begin
                mn = 32'((it.crawl_delay > floor_delay) ? it.crawl_delay : floor_delay);
                flow_floor[f] = mn[DELAY_W-1:0];
                if (mn > dly) dly = mn;
                flow_delay[f] = dly[DELAY_W-1:0];
            end
            default: ;
        endcase
        res.wait_time = (hold > 64'(WAIT_SAT)) ? WAIT_SAT : hold[DELAY_W-1:0];
        res.delay_now = flow_delay[f];
        res.flow_out  = it.flow;
        return res;
    endfunction

    function automatic t_in_item mk_item(
        input logic [CMD_W-1:0]   c,
        input logic [FLOW_W-1:0]  f,
        input logic [TIME_W-1:0]  t,
        input logic [DELAY_W-1:0] rt,
        input logic [STAT_W-1:0]  st,
        input logic [DELAY_W-1:0] cd
    );
        t_in_item it;
        it.cmd = c;
        it.flow = f;
        it.now = t;
        it.resp_time = rt;
        it.resp_status = st;
        it.crawl_delay = cd;
        return it;
    endfunction

    function automatic bit limiter_busy();
        return limiter_items.size() != 0 || in_valid || predicted.size() != 0;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("mismatch %s: got %0d, want %0d", what, got, exp_val);
        mismatches++;
    endtask

    // one register write, valid stays up so writes can follow back to back
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_DLY_CAP:   cap_delay = val;
            REG_BASE_MIN:  floor_delay = val;
            REG_ERR_LIMIT: err_trip = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // driver: presents queued items, random gap before each new transfer unless tx_burst is set
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end else if (!(in_valid && in_stall)) begin
            // transfer happened on this edge
            if (in_valid) predicted.push_back(pace_flow(in_data));
            if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end else if (limiter_items.size() != 0) begin
                in_data  <= limiter_items.pop_front();
                in_valid <= 1'b1;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 3);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transfer, then stalls for a random count unless rx_burst is set
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (predicted.size() == 0) begin
                    report_mismatch("unexpected result, flow", longint'(out_data.flow_out),
                        -64'sd1);
                end else begin
                    want = predicted.pop_front();
                    if (out_data.wait_time != want.wait_time)
                        report_mismatch("wait_time", longint'(out_data.wait_time),
                            longint'(want.wait_time));
                    if (out_data.delay_now != want.delay_now)
                        report_mismatch("delay_now", longint'(out_data.delay_now),
                            longint'(want.delay_now));
                    if (out_data.flow_out != want.flow_out)
                        report_mismatch("flow_out", longint'(out_data.flow_out),
                            longint'(want.flow_out));
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            out_stall <= (rx_wait > 0);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int ph;
        int n;
        int sel;
        int len;
        logic [FLOW_W-1:0]  f;
        logic [TIME_W-1:0]  clk_now;
        logic [DELAY_W-1:0] rt;
        logic [STAT_W-1:0]  st;
        logic [DELAY_W-1:0] cap;
        logic [DELAY_W-1:0] base;
        logic [CNT_W-1:0]   trip;

        cap_delay = DLY_CAP_RST;
        floor_delay = BASE_MIN_RST;
        err_trip = ERR_LIMIT_RST;
        for (int i = 0; i < AFRL_FLOWS; i++) begin
            flow_delay[i] = DELAY_RST;
            flow_floor[i] = DELAY_RST;
            flow_errs[i] = '0;
            flow_release[i] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items under reset register values
        // request at release, before release, long after release
        limiter_items.push_back(mk_item(CMD_REQUEST, 4'd0, 32'd0, '1, '1, '1));
        limiter_items.push_back(mk_item(CMD_REQUEST, 4'd0, 32'd100, 16'd0, 10'd0, 16'd0));
        limiter_items.push_back(mk_item(CMD_REQUEST, 4'd0, 32'hFFFF_FFFF, '0, '0, '0));
        // release wraps past the top of the time range
        limiter_items.push_back(mk_item(CMD_REQUEST, 4'd1, 32'hFFFF_FF00, '0, '0, '0));
        limiter_items.push_back(mk_item(CMD_REQUEST, 4'd1, 32'd5, '0, '0, '0));
        // release far ahead of now, reported wait saturates
        limiter_items.push_back(mk_item(CMD_REQUEST, 4'd2, 32'h8000_0000, '0, '0, '0));
        limiter_items.push_back(mk_item(CMD_REQUEST, 4'd2, 32'd0, '0, '0, '0));
        // error run reaching the limit, one more error, a good answer clearing the count, one more error
        repeat (3) limiter_items.push_back(mk_item(CMD_RESPONSE, 4'd3, '1, '1, 10'd400, '1));
        limiter_items.push_back(mk_item(CMD_RESPONSE, 4'd3, '0, '0, '1, '0));
        limiter_items.push_back(mk_item(CMD_RESPONSE, 4'd3, '0, 16'd256, 10'd399, '0));
        limiter_items.push_back(mk_item(CMD_RESPONSE, 4'd3, '0, '0, 10'd1023, '0));
        // slow answer, fast answers down to the floor, answer equal to the delay
        limiter_items.push_back(mk_item(CMD_RESPONSE, 4'd4, '0, 16'hFFFF, 10'd0, '0));
        limiter_items.push_back(mk_item(CMD_RESPONSE, 4'd4, '0, 16'd0, 10'd0, '0));
        limiter_items.push_back(mk_item(CMD_RESPONSE, 4'd4, '0, 16'd0, 10'd200, '0));
        limiter_items.push_back(mk_item(CMD_RESPONSE, 4'd4, '0, 16'd256, 10'd200, '0));
        // crawl delay at the top, then a fast answer held at the new minimum
        limiter_items.push_back(mk_item(CMD_CRAWL, 4'd5, '1, '1, '1, 16'hFFFF));
        limiter_items.push_back(mk_item(CMD_RESPONSE, 4'd5, '0, 16'd0, 10'd0, '0));
        limiter_items.push_back(mk_item(CMD_REQUEST, 4'd5, 32'd1000, '0, '0, '0));
        // crawl delay below the base minimum
        limiter_items.push_back(mk_item(CMD_CRAWL, 4'd6, '0, '0, '0, 16'd0));
        // unused command with every field set
        limiter_items.push_back(mk_item(CMD_UNUSED, 4'd7, '1, '1, '1, '1));
        limiter_items.push_back(mk_item(CMD_REQUEST, 4'd15, 32'd12345, '0, '0, '0));

        for (ph = 0; ph < PHASES; ph++) begin
            // sender holds off until every result is back, then registers change
            do @(negedge clk); while (limiter_busy());
            repeat (SETTLE) @(posedge clk);
            if (ph == RAND_PHASE) begin
                cap = 16'($urandom_range(1, 65535));
                base = 16'($urandom);
                trip = 4'($urandom_range(1, 15));
            end else begin
                cap = CAP_SET[ph];
                base = BASE_SET[ph];
                trip = TRIP_SET[ph];
            end
            cfg_write(REG_DLY_CAP, cap);
            cfg_write(REG_BASE_MIN, base);
            // upper data bits are noise, only the low nibble counts
            cfg_write(REG_ERR_LIMIT, {12'($urandom), trip});
            cfg_valid <= 1'b0;
            @(negedge clk);

            // all four combinations of gapped and back-to-back traffic
            tx_burst = ph[0];
            rx_burst = ph[1];

            n = 0;
            clk_now = $urandom;
            while (n < PHASE_ITEMS) begin
                f = 4'($urandom_range(0, AFRL_FLOWS - 1));
                sel = $urandom_range(0, 99);
                if (sel < 6) begin
                    // burst of errors on one flow
                    len = $urandom_range(1, 16);
                    repeat (len) begin
                        limiter_items.push_back(mk_item(CMD_RESPONSE, f, $urandom,
                            16'($urandom), 10'($urandom_range(400, 1023)),
                            16'($urandom)));
                        n++;
                    end
                end else if (sel < 46) begin
                    // time mostly moves forward in small steps, now and then jumps
                    if ($urandom_range(0, 19) == 0)
                        clk_now = $urandom;
                    else
                        clk_now = clk_now + $urandom_range(0, 700);
                    limiter_items.push_back(mk_item(CMD_REQUEST, f, clk_now, 16'($urandom),
                        10'($urandom), 16'($urandom)));
                    n++;
                end else if (sel < 84) begin
                    st = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(400, 1023))
                                                     : 10'($urandom_range(0, 399));
                    case ($urandom_range(0, 3))
                        0: rt = 16'($urandom);
                        1: rt = 16'($urandom_range(0, flow_delay[f] >> 1));
                        2: rt = 16'(flow_delay[f] + $urandom_range(0, 2) - 1);
                        default: rt = 16'(flow_delay[f] >> 1);
                    endcase
                    limiter_items.push_back(mk_item(CMD_RESPONSE, f, $urandom, rt, st,
                        16'($urandom)));
                    n++;
                end else if (sel < 96) begin
                    limiter_items.push_back(mk_item(CMD_CRAWL, f, $urandom, 16'($urandom),
                        10'($urandom),
                        ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 3000))));
                    n++;
                end else begin
                    limiter_items.push_back(mk_item(CMD_UNUSED, f, $urandom, 16'($urandom),
                        10'($urandom), 16'($urandom)));
                    n++;
                end
            end
        end

        do @(negedge clk); while (limiter_busy());
        repeat (8) @(posedge clk);
        if (predicted.size() != 0)
            report_mismatch("results never delivered", 64'sd0, longint'(predicted.size()));
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/afrl_pkg.sv
rtl/core/afrl_table.sv
rtl/core/afrl_update.sv
rtl/core/adaptive_per_flow_rate_limiter_unit.sv
test/tb_adaptive_per_flow_rate_limiter_unit.sv
